// ----- rtl/tksd_pkg.sv -----
// Package: shared types and constants of the terminal key sequence decoder.
`default_nettype none
package tksd_pkg;

	localparam int SEQ_BUFFER_SIZE = 8;
	localparam int CNT_W           = $clog2(SEQ_BUFFER_SIZE);

	localparam logic [7:0] KEY_ESC  = 8'h1B;
	localparam logic [7:0] KEY_DEL  = 8'h7F;
	localparam logic [7:0] CTRL_TOP = 8'h20;
	localparam logic [7:0] CH_CSI   = 8'h5B; // '['
	localparam logic [7:0] CH_SS3   = 8'h4F; // 'O'
	localparam logic [7:0] CH_TILDE = 8'h7E; // '~'
	localparam logic [7:0] CH_UP    = 8'h41; // 'A'
	localparam logic [7:0] CH_DOWN  = 8'h42; // 'B'
	localparam logic [7:0] CH_RIGHT = 8'h43; // 'C'
	localparam logic [7:0] CH_LEFT  = 8'h44; // 'D'
	localparam logic [7:0] CH_END   = 8'h46; // 'F'
	localparam logic [7:0] CH_HOME  = 8'h48; // 'H'
	localparam logic [7:0] CH_ONE   = 8'h31; // '1'
	localparam logic [7:0] CH_THREE = 8'h33; // '3'
	localparam logic [7:0] CH_FOUR  = 8'h34; // '4'
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESC    = 2'd1,
		PH_CSI    = 2'd2,
		PH_SS3    = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		EV_PRINT  = 4'd0,
		EV_CTRL   = 4'd1,
		EV_UP     = 4'd2,
		EV_DOWN   = 4'd3,
		EV_LEFT   = 4'd4,
		EV_RIGHT  = 4'd5,
		EV_HOME   = 4'd6,
		EV_END    = 4'd7,
		EV_DELETE = 4'd8
	} event_t;

	typedef struct packed {
		logic   hit;
		event_t kind;
	} key_ev_t;

	function automatic logic is_final(input logic [7:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)
			|| c == CH_TILDE;
	endfunction

	function automatic key_ev_t single_final(input logic [7:0] c);
		key_ev_t r;
		r.hit  = 1'b1;
		r.kind = EV_PRINT;
		unique case (c)
			CH_UP:    r.kind = EV_UP;
			CH_DOWN:  r.kind = EV_DOWN;
			CH_RIGHT: r.kind = EV_RIGHT;
			CH_LEFT:  r.kind = EV_LEFT;
			CH_HOME:  r.kind = EV_HOME;
			CH_END:   r.kind = EV_END;
			default:  r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tksd_if.sv -----
// Interfaces: input byte channel and key event channel.
`default_nettype none
interface tksd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tksd_event_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_kind;
	logic [7:0] key_byte;

	modport source (output valid, output event_kind, output key_byte, input ready);
	modport sink (input valid, input event_kind, input key_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/terminal_key_sequence_decoder.sv -----
// Top level: terminal byte to key event decoder with escape sequence tracking.
// One received byte per transaction on rx, at most one key event per byte on evt.
// Throughput is one byte per clock while evt accepts events (evt.ready low
// stalls rx): a byte is registered in byte_s1, decoded against the sequence
// state and its event lands in the output register. ESC, the byte after it,
// and non-final CSI bytes produce no event; unknown or malformed sequences are dropped.
`default_nettype none
module terminal_key_sequence_decoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tksd_byte_if.sink         rx,
	tksd_event_if.source      evt
);

	localparam logic [tksd_pkg::CNT_W-1:0] CNT_MAX =
		tksd_pkg::CNT_W'(tksd_pkg::SEQ_BUFFER_SIZE - 1);
	localparam logic [tksd_pkg::CNT_W-1:0] CNT_ZERO = '0;
	localparam logic [tksd_pkg::CNT_W-1:0] CNT_ONE  = tksd_pkg::CNT_W'(1);
	localparam logic [tksd_pkg::CNT_W-1:0] CNT_TWO  = tksd_pkg::CNT_W'(2);

	logic                       v_s1;
	logic [7:0]                 byte_s1;
	logic                       v_s2;
	tksd_pkg::event_t           kind_s2;
	logic [7:0]                 key_s2;

	tksd_pkg::phase_t           phase_q, phase_d;
	logic [tksd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0]                 first_q, first_d, first_inc;

	tksd_pkg::key_ev_t          ev;
	logic [7:0]                 kb;
	logic                       advance;
	logic                       fin;

	assign advance  = !v_s2 || evt.ready;
	assign rx.ready = !v_s1 || advance;
	assign fin      = tksd_pkg::is_final(byte_s1);

	// CSI count and first byte after this byte
	assign cnt_inc   = (cnt_q < CNT_MAX) ? cnt_q + CNT_ONE : cnt_q;
	assign first_inc = (cnt_q == CNT_ZERO) ? byte_s1 : first_q;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		unique case (phase_q)
			tksd_pkg::PH_NORMAL: begin
				if (byte_s1 == tksd_pkg::KEY_ESC) begin
					phase_d = tksd_pkg::PH_ESC;
				end
			end
			tksd_pkg::PH_ESC: begin
				if (byte_s1 == tksd_pkg::CH_CSI) begin
					phase_d = tksd_pkg::PH_CSI;
				end else if (byte_s1 == tksd_pkg::CH_SS3) begin
					phase_d = tksd_pkg::PH_SS3;
				end else begin
					phase_d = tksd_pkg::PH_NORMAL;
					cnt_d   = CNT_ZERO;
					first_d = '0;
				end
			end
			tksd_pkg::PH_CSI: begin
				if (fin) begin
					phase_d = tksd_pkg::PH_NORMAL;
					cnt_d   = CNT_ZERO;
					first_d = '0;
				end else begin
					cnt_d   = cnt_inc;
					first_d = first_inc;
				end
			end
			tksd_pkg::PH_SS3: begin
				phase_d = tksd_pkg::PH_NORMAL;
				cnt_d   = CNT_ZERO;
				first_d = '0;
			end
			default: phase_d = tksd_pkg::PH_NORMAL;
		endcase
	end

	always_comb begin
		ev.hit  = 1'b0;
		ev.kind = tksd_pkg::EV_PRINT;
		kb      = '0;
		unique case (phase_q)
			tksd_pkg::PH_NORMAL: begin
				if (byte_s1 != tksd_pkg::KEY_ESC) begin
					ev.hit = 1'b1;
					kb     = byte_s1;
					if (byte_s1 < tksd_pkg::CTRL_TOP || byte_s1 == tksd_pkg::KEY_DEL) begin
						ev.kind = tksd_pkg::EV_CTRL;
					end
				end
			end
			tksd_pkg::PH_ESC: ev.hit = 1'b0;
			tksd_pkg::PH_CSI: begin
				if (fin && cnt_inc == CNT_ONE) begin
					ev = tksd_pkg::single_final(byte_s1);
				end else if (fin && cnt_inc == CNT_TWO && byte_s1 == tksd_pkg::CH_TILDE) begin
					priority if (first_inc == tksd_pkg::CH_ONE) begin
						ev.hit  = 1'b1;
						ev.kind = tksd_pkg::EV_HOME;
					end else if (first_inc == tksd_pkg::CH_THREE) begin
						ev.hit  = 1'b1;
						ev.kind = tksd_pkg::EV_DELETE;
					end else if (first_inc == tksd_pkg::CH_FOUR) begin
						ev.hit  = 1'b1;
						ev.kind = tksd_pkg::EV_END;
					end else begin
						ev.hit  = 1'b0;
					end
				end
			end
			tksd_pkg::PH_SS3: ev = tksd_pkg::single_final(byte_s1);
			default: ev.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			phase_q <= tksd_pkg::PH_NORMAL;
			cnt_q   <= CNT_ZERO;
			first_q <= '0;
		end else begin
			if (rx.valid && rx.ready) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				v_s2 <= v_s1 && ev.hit;
			end
			if (advance && v_s1) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				first_q <= first_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
		end
		if (advance && v_s1) begin
			kind_s2 <= ev.kind;
			key_s2  <= kb;
		end
	end

	assign evt.valid      = v_s2;
	assign evt.event_kind = kind_s2;
	assign evt.key_byte   = key_s2;

endmodule
`default_nettype wire
